// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the dual peak locator.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dpl_pkg.sv =====
// Package of the dual peak locator: widths, constants and shared structs.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dpl_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 8;
    localparam int MAX_SAMPLES = 4096;
    localparam int POS_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = POS_W + 1;
    localparam int REF_W       = 16;
    localparam int TIME_W      = 25;
    localparam int IN_W        = 2 * SAMPLE_W;
    localparam int OUT_W       = ((2 * TIME_W + 2 + 7) / 8) * 8;

    localparam int NUM_W       = SAMPLE_W + 1;
    localparam int CURV_W      = SAMPLE_W + 3;
    localparam int DEN_W       = CURV_W + 1;
    localparam int DVD_W       = NUM_W + FRAC_W + 2;
    localparam int DVS_W       = DEN_W + 1;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
    localparam int WIDE_W      = DVD_W + REF_W + 2;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(2000);

    localparam logic [1:0] ST_TRACK  = 2'd0;
    localparam logic [1:0] ST_SETUP  = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;
    localparam logic [1:0] ST_LOAD   = 2'd3;

    typedef struct packed {
        logic             beat;
        logic             last;
        logic             idx_ok;
        logic [POS_W-1:0] idx;
        logic             start;
    } lane_ctrl_t;

    typedef struct packed {
        logic                     busy;
        logic signed [TIME_W-1:0] time_val;
        logic                     found;
    } lane_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dpl_divider.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
// Depends on dpl_pkg for the dividend and divisor widths.
`default_nettype none

module dpl_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dpl_pkg::DVD_W-1:0]  dividend,
    input  wire logic [dpl_pkg::DVS_W-1:0]  divisor,
    output logic                            busy,
    output logic [dpl_pkg::DVD_W-1:0]       quotient
);
    import dpl_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DVD_W);
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/dpl_lane.sv =====
// One channel lane: peak tracking, three-point parabola setup and the time result.
// Depends on dpl_pkg and instantiates dpl_divider.
`default_nettype none

module dpl_lane (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dpl_pkg::lane_ctrl_t               ctrl,
    input  wire logic signed [dpl_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [dpl_pkg::REF_W-1:0]         ref_index,
    output dpl_pkg::lane_stat_t                    stat
);
    import dpl_pkg::*;

    logic signed [SAMPLE_W-1:0] best_reg, before_reg, after_reg, prev_reg;
    logic [POS_W-1:0]           pos_reg;
    logic                       await_reg;

    logic signed [SAMPLE_W-1:0] best_next, before_next, after_next, prev_next;
    logic [POS_W-1:0]           pos_next;
    logic                       await_next;

    logic signed [SAMPLE_W-1:0] snap_y0_reg, snap_ym1_reg, snap_yp1_reg;
    logic [POS_W-1:0]           snap_pos_reg;
    logic                       snap_found_reg, snap_plain_reg;

    logic signed [NUM_W-1:0]    num;
    logic signed [CURV_W-1:0]   curv;
    logic signed [DEN_W-1:0]    den;
    logic [NUM_W-1:0]           num_abs;
    logic [DEN_W-1:0]           den_abs;
    logic                       neg;
    logic [DVD_W-1:0]           dividend;
    logic [DVS_W-1:0]           divisor;
    logic [DVD_W-1:0]           quotient;
    logic                       div_busy;

    logic signed [WIDE_W-1:0]   base_w, q_w, ref_w, refined_w, diff_w;

    always_comb
    begin
        best_next   = best_reg;
        before_next = before_reg;
        after_next  = after_reg;
        prev_next   = prev_reg;
        pos_next    = pos_reg;
        await_next  = await_reg;
        if (ctrl.idx_ok)
        begin
            if (await_reg)
            begin
                after_next = sample;
                await_next = 1'b0;
            end
            if (sample > best_reg)
            begin
                best_next   = sample;
                pos_next    = ctrl.idx;
                before_next = prev_reg;
                await_next  = 1'b1;
            end
            prev_next = sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg   <= '0;
            before_reg <= '0;
            after_reg  <= '0;
            prev_reg   <= '0;
            pos_reg    <= '0;
            await_reg  <= 1'b0;
        end
        else if (ctrl.beat && ctrl.last)
        begin
            best_reg   <= '0;
            before_reg <= '0;
            after_reg  <= '0;
            prev_reg   <= '0;
            pos_reg    <= '0;
            await_reg  <= 1'b0;
        end
        else if (ctrl.beat)
        begin
            best_reg   <= best_next;
            before_reg <= before_next;
            after_reg  <= after_next;
            prev_reg   <= prev_next;
            pos_reg    <= pos_next;
            await_reg  <= await_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.beat && ctrl.last)
        begin
            snap_y0_reg    <= best_next;
            snap_ym1_reg   <= before_next;
            snap_yp1_reg   <= after_next;
            snap_pos_reg   <= pos_next;
            snap_found_reg <= best_next > $signed(SAMPLE_W'(0));
            snap_plain_reg <= (pos_next == '0) || await_next;
        end
    end

    always_comb
    begin
        num = $signed({snap_ym1_reg[SAMPLE_W-1], snap_ym1_reg})
            - $signed({snap_yp1_reg[SAMPLE_W-1], snap_yp1_reg});
        curv = $signed({{3{snap_ym1_reg[SAMPLE_W-1]}}, snap_ym1_reg})
             - $signed({{2{snap_y0_reg[SAMPLE_W-1]}}, snap_y0_reg, 1'b0})
             + $signed({{3{snap_yp1_reg[SAMPLE_W-1]}}, snap_yp1_reg});
        den      = $signed({curv, 1'b0});
        num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_abs  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        neg      = num[NUM_W-1] != den[DEN_W-1];
        dividend = {1'b0, num_abs, {FRAC_W{1'b0}}, 1'b0}
                 + {{(DVD_W-DEN_W){1'b0}}, den_abs};
        divisor  = {den_abs, 1'b0};
    end

    dpl_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        base_w = $signed({{(WIDE_W-POS_W-FRAC_W){1'b0}}, snap_pos_reg, {FRAC_W{1'b0}}});
        q_w    = $signed({{(WIDE_W-DVD_W){1'b0}}, quotient});
        ref_w  = $signed({{(WIDE_W-REF_W-FRAC_W){1'b0}}, ref_index, {FRAC_W{1'b0}}});
        if (snap_plain_reg || (curv == '0))
        begin
            refined_w = base_w;
        end
        else if (neg)
        begin
            refined_w = base_w - q_w;
        end
        else
        begin
            refined_w = base_w + q_w;
        end
        diff_w = ref_w - refined_w;
    end

    assign stat.busy     = div_busy;
    assign stat.found    = snap_found_reg;
    assign stat.time_val = snap_found_reg ? $signed(diff_w[TIME_W-1:0]) : '0;

endmodule

`default_nettype wire

// ===== rtl/dpl_merge.sv =====
// Merge stage: joins the two lane results into one output beat and holds it.
// Depends on dpl_pkg for the lane result struct and the output width.
`default_nettype none

module dpl_merge (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire dpl_pkg::lane_stat_t     lane_full,
    input  wire dpl_pkg::lane_stat_t     lane_diff,
    output logic                         space,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [dpl_pkg::OUT_W-1:0]    m_axis_tdata
);
    import dpl_pkg::*;

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] data_reg;

    assign space = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {{(OUT_W-2*TIME_W-2){1'b0}}, lane_diff.found, lane_full.found,
                         lane_diff.time_val, lane_full.time_val};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/dual_peak_parabolic_locator_top.sv =====
// Top level of the dual peak locator: sample counter, sequencer and configuration.
// Depends on dpl_pkg, assert_macros.svh, dpl_lane and dpl_merge.
//
// Channel   Direction  Bits  Contents
// s_axis    in         32    sample_full, sample_diff; tlast ends the frame
// m_axis    out        56    time_full, time_diff, found_full, found_diff
// cfg       in         16    reference_index write
//
// Samples are taken one beat per cycle while a frame is tracked.
// After the last beat the input stalls through a setup state, then a divide state in which
// the per-lane restoring divider runs its 27 steps and the sequencer sees it finish,
// then a load state that loads the output register.
// The output register lets the next frame stream while the result waits;
// a result not yet taken holds the following frame end, and the input, in the load cycle.
// Reset sets reference_index to 2000 and clears the control and tracking state, not the data.
`default_nettype none

`include "assert_macros.svh"

module dual_peak_parabolic_locator_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample_full [15:0], sample_diff [31:16]
    input  wire logic [dpl_pkg::IN_W-1:0]   s_axis_tdata,
    input  wire logic                       s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // time_full [24:0], time_diff [49:25], found_full [50], found_diff [51]
    output logic [dpl_pkg::OUT_W-1:0]       m_axis_tdata,
    input  wire logic                       cfg_wr_en,
    input  wire logic [dpl_pkg::REF_W-1:0]  cfg_wr_data
);
    import dpl_pkg::*;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [REF_W-1:0] ref_reg;
    logic             beat;
    logic             idx_ok;
    logic             load;
    logic             space;
    lane_ctrl_t       ctrl;
    lane_stat_t       stat_full, stat_diff;

    assign s_axis_tready = state_reg == ST_TRACK;
    assign beat          = s_axis_tvalid && s_axis_tready;
    assign idx_ok        = idx_reg < CNT_W'(MAX_SAMPLES);
    assign load          = (state_reg == ST_LOAD) && space;

    assign ctrl.beat   = beat;
    assign ctrl.last   = s_axis_tlast;
    assign ctrl.idx_ok = idx_ok;
    assign ctrl.idx    = idx_reg[POS_W-1:0];
    assign ctrl.start  = state_reg == ST_SETUP;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_TRACK:
            begin
                if (beat)
                begin
                    if (s_axis_tlast)
                    begin
                        idx_next   = '0;
                        state_next = ST_SETUP;
                    end
                    else if (idx_ok)
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_SETUP:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!stat_full.busy && !stat_diff.busy)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (space)
                begin
                    state_next = ST_TRACK;
                end
            end
            default:
            begin
                state_next = ST_TRACK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TRACK;
            idx_reg   <= '0;
            ref_reg   <= REF_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en)
            begin
                ref_reg <= cfg_wr_data;
            end
        end
    end

    dpl_lane u_lane_full (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample    ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .ref_index (ref_reg),
        .stat      (stat_full)
    );

    dpl_lane u_lane_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample    ($signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .ref_index (ref_reg),
        .stat      (stat_diff)
    );

    dpl_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .lane_full     (stat_full),
        .lane_diff     (stat_diff),
        .space         (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_ALWAYS(a_last_starts_setup, clk, rst_n, (beat && s_axis_tlast) |=> (state_reg == ST_SETUP), "last beat did not start the setup cycle")
    `ASSERT_ALWAYS(a_lanes_in_step, clk, rst_n, (state_reg == ST_DIVIDE) |-> (stat_full.busy == stat_diff.busy), "lane dividers out of step")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, load && m_axis_tvalid && !m_axis_tready, "result loaded over a waiting beat")
    `ASSERT_ALWAYS(a_index_bound, clk, rst_n, idx_reg <= CNT_W'(MAX_SAMPLES), "sample index beyond saturation")

endmodule

`default_nettype wire
